// File: hw/rtl/ansp_pkg.sv
// ansp_pkg: shared types, character codes and character-class functions
// for the AML name string parser. No dependencies.
package ansp_pkg;

	// Characters that steer the prefix and segment-count decode and the character classes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_CARET  = 8'h5E; // '^'
	localparam logic [7:0] CH_BSLASH = 8'h5C; // '\'
	localparam logic [7:0] CH_DOT    = 8'h2E; // '.'
	localparam logic [7:0] CH_SLASH  = 8'h2F; // '/'
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_UNDER  = 8'h5F; // '_'
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;

	localparam logic [7:0] DUAL_SEG_COUNT = 8'd2;
	localparam logic [7:0] SINGLE_SEG_COUNT = 8'd1;
	localparam logic [7:0] CARET_MAX = 8'd255;
	localparam logic [1:0] LAST_CHAR_POS = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_CARETS  = 3'd1,
		PH_ROOTED  = 3'd2,
		PH_COUNT   = 3'd3,
		PH_SEGMENT = 3'd4
	} ansp_phase_t;

	typedef struct packed {
		logic [31:0] word;
		logic [7:0]  index;
		logic [7:0]  total;
		logic [7:0]  levels;
		logic        root;
		logic        status;
		logic        last;
	} ansp_result_t;

	// First segment character: A-Z or underscore
	function automatic logic is_lead_char(input logic [7:0] c);
		return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || (c == CH_UNDER);
	endfunction

	// Later segment characters also allow digits
	function automatic logic is_name_char(input logic [7:0] c);
		return is_lead_char(c) || ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9));
	endfunction

endpackage

// File: hw/rtl/aml_name_string_parser.sv
// aml_name_string_parser: top level of the AML name string parser.
// Depends on ansp_pkg, ansp_fsm and ansp_out_reg.

// Takes an AML name string one byte per transfer and returns one result per
// completed four-character segment, or a single result for a zero-segment name
// or an invalid character (status_code 1). A transferred byte is held in the input
// register until the decode state machine consumes it; when that byte forms a
// result, the state machine writes the output register, so each result passes
// through the input register and then the output register. Bytes are taken one
// per clock unless a byte that forms a result stalls on a full output slot. A byte
// that produces no result is consumed even while the output register holds a
// pending transfer; a byte that does produce one waits until the output slot
// frees. last_of_name marks the final result of each name and every error;
// the next byte then starts a new name.
module aml_name_string_parser
	import ansp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] segment_word,
	output logic [7:0]  segment_index,
	output logic [7:0]  segment_total,
	output logic [7:0]  parent_levels,
	output logic        from_root,
	output logic        status_code,
	output logic        last_of_name
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         advance;
	logic         emit;
	ansp_result_t fsm_result;
	ansp_result_t result_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= data_byte;
	end

	// byte moves on unless it makes a result and the output slot is stuck
	assign advance  = valid_s1 && (!emit || !out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	ansp_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.byte_in (byte_s1),
		.emit    (emit),
		.result  (fsm_result)
	);

	ansp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && emit),
		.result_in (fsm_result),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_q  (result_q)
	);

	assign segment_word  = result_q.word;
	assign segment_index = result_q.index;
	assign segment_total = result_q.total;
	assign parent_levels = result_q.levels;
	assign from_root     = result_q.root;
	assign status_code   = result_q.status;
	assign last_of_name  = result_q.last;

	// a new result never overwrites one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |-> (!out_valid || out_ready))
		else $error("result register overwritten");

	// errors always end the name
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status_code) |-> last_of_name)
		else $error("error result without last flag");

	// zero-segment names give one empty, final result
	a_empty_name: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !status_code && segment_total == 8'd0)
		|-> (last_of_name && segment_word == 32'd0 && segment_index == 8'd0))
		else $error("bad zero-segment result");

	// a good segment lies inside the declared count
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !status_code && segment_total != 8'd0)
		|-> (segment_index < segment_total))
		else $error("segment index beyond declared count");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(result_q)))
		else $error("stalled result changed");

endmodule

// File: hw/rtl/ansp_fsm.sv
// ansp_fsm: name decode state machine; consumes one byte per step and
// forms at most one result. Depends on ansp_pkg.
module ansp_fsm
	import ansp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   byte_in,
	output logic         emit,
	output ansp_result_t result
);

	ansp_phase_t phase_q, phase_d;
	logic [7:0]  caret_q, caret_d;
	logic        root_q, root_d;
	logic [7:0]  decl_q, decl_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [1:0]  pos_q, pos_d;
	logic [23:0] acc_q, acc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			caret_q <= '0;
			root_q  <= 1'b0;
			decl_q  <= '0;
			cnt_q   <= '0;
			pos_q   <= '0;
			acc_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			caret_q <= caret_d;
			root_q  <= root_d;
			decl_q  <= decl_d;
			cnt_q   <= cnt_d;
			pos_q   <= pos_d;
			acc_q   <= acc_d;
		end
	end

	logic        decide, take, empty, clear;
	logic [1:0]  pos_use;
	logic [7:0]  cnt_use, decl_use;
	logic [23:0] acc_use;
	logic        seg_last;

	always_comb begin
		phase_d = phase_q;
		caret_d = caret_q;
		root_d  = root_q;
		decl_d  = decl_q;
		cnt_d   = cnt_q;
		pos_d   = pos_q;
		acc_d   = acc_q;
		decide  = 1'b0;
		take    = 1'b0;
		empty   = 1'b0;
		clear   = 1'b0;
		emit    = 1'b0;
		seg_last = 1'b0;
		result  = '{word: '0, index: '0, total: decl_q, levels: caret_q,
			root: root_q, status: 1'b0, last: 1'b0};

		unique case (phase_q)
			PH_IDLE: begin
				if (byte_in == CH_CARET) begin
					caret_d = 8'd1;
					phase_d = PH_CARETS;
				end else if (byte_in == CH_BSLASH) begin
					root_d  = 1'b1;
					phase_d = PH_ROOTED;
				end else begin
					decide = 1'b1;
				end
			end
			PH_CARETS: begin
				if (byte_in == CH_CARET) begin
					if (caret_q != CARET_MAX) caret_d = caret_q + 8'd1;
				end else begin
					decide = 1'b1;
				end
			end
			PH_ROOTED: decide = 1'b1;
			PH_COUNT: begin
				if (byte_in == CH_NUL) begin
					empty = 1'b1;
				end else begin
					decl_d  = byte_in;
					phase_d = PH_SEGMENT;
				end
			end
			PH_SEGMENT: take = 1'b1;
			default: clear = 1'b1;
		endcase

		// byte after the prefix picks the segment count
		if (decide) begin
			cnt_d = '0;
			pos_d = '0;
			acc_d = '0;
			if (byte_in == CH_NUL) begin
				empty = 1'b1;
			end else if (byte_in == CH_DOT) begin
				decl_d  = DUAL_SEG_COUNT;
				phase_d = PH_SEGMENT;
			end else if (byte_in == CH_SLASH) begin
				phase_d = PH_COUNT;
			end else begin
				take = 1'b1;
			end
		end

		// a plain first byte is itself the first char of a one-segment name
		pos_use  = decide ? 2'd0 : pos_q;
		cnt_use  = decide ? 8'd0 : cnt_q;
		decl_use = decide ? SINGLE_SEG_COUNT : decl_q;
		acc_use  = decide ? 24'd0 : acc_q;

		if (empty) begin
			emit = 1'b1;
			result.total = '0;
			result.last  = 1'b1;
			clear = 1'b1;
		end

		if (take) begin
			result.total = decl_use;
			result.index = cnt_use;
			if (!((pos_use == 2'd0) ? is_lead_char(byte_in) : is_name_char(byte_in))) begin
				emit = 1'b1;
				result.status = 1'b1;
				result.last   = 1'b1;
				clear = 1'b1;
			end else if (pos_use != LAST_CHAR_POS) begin
				acc_d = acc_use;
				acc_d[8*pos_use +: 8] = byte_in;
				pos_d   = pos_use + 2'd1;
				cnt_d   = cnt_use;
				decl_d  = decl_use;
				phase_d = PH_SEGMENT;
			end else begin
				seg_last = ({1'b0, cnt_use} + 9'd1) >= {1'b0, decl_use};
				emit = 1'b1;
				result.word = {byte_in, acc_use};
				result.last = seg_last;
				if (seg_last) begin
					clear = 1'b1;
				end else begin
					cnt_d   = cnt_use + 8'd1;
					pos_d   = '0;
					acc_d   = '0;
					decl_d  = decl_use;
					phase_d = PH_SEGMENT;
				end
			end
		end

		if (clear) begin
			phase_d = PH_IDLE;
			caret_d = '0;
			root_d  = 1'b0;
			decl_d  = '0;
			cnt_d   = '0;
			pos_d   = '0;
			acc_d   = '0;
		end
	end

endmodule

// File: hw/rtl/ansp_out_reg.sv
// ansp_out_reg: result register with valid/ready on the output side.
// Depends on ansp_pkg.
module ansp_out_reg
	import ansp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  ansp_result_t result_in,
	output logic         out_valid,
	input  logic         out_ready,
	output ansp_result_t result_q
);

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) result_q <= result_in;
	end

	assign out_valid = valid_q;

endmodule
